/* src/rlicd_pkg.sv */
// ---------------------------------------------------------------------------
// rlicd_pkg: run-length image chunk decoder package
// Item types, phase and status codes, and chunk constants.
// ---------------------------------------------------------------------------
package rlicd_pkg;

	// signature chunk bytes
	localparam logic [7:0] SIG_B0 = 8'h89;
	localparam logic [7:0] SIG_B1 = 8'h5A;
	localparam logic [7:0] SIG_B2 = 8'h50;
	localparam logic [7:0] SIG_B3 = 8'h49;
	localparam logic [7:0] SIG_B4 = 8'h46;
	localparam logic [7:0] SIG_B5 = 8'h0A;

	// parameter tags and closing mark
	localparam logic [7:0] TAG_WIDTH  = 8'h77;
	localparam logic [7:0] TAG_HEIGHT = 8'h68;
	localparam logic [7:0] END_MARK   = 8'hFF;

	localparam logic MODE_CHUNK = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef enum logic [2:0] {
		PH_SIG   = 3'd0,
		PH_PARAM = 3'd1,
		PH_PIXEL = 3'd2,
		PH_ENDED = 3'd3,
		PH_ERROR = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_ZERO_DIM  = 3'd2,
		ST_ENDED     = 3'd3,
		ST_PENDING   = 3'd4,
		ST_IGNORED   = 3'd5
	} status_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [7:0] byte5;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        pixel_valid;
		logic [31:0] pix_x;
		logic [31:0] pix_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        run_last;
		logic        out_of_frame;
	} res_t;

endpackage

/* src/run_length_image_chunk_decoder.sv */
// ---------------------------------------------------------------------------
// run_length_image_chunk_decoder: six-byte chunk stream to RGBA pixels
// Parses signature, frame size and run chunks, then hands out pixels.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req): one item is either a six-byte
//    chunk (mode 0) or a request for the next pixel of the pending run
//    (mode 1).
//  - res channel (res_valid/res_ready/res): exactly one result item per
//    request item, in order. status reports chunk handling; pixel_valid
//    marks an item carrying a pixel with its x/y and colour.
//  - Results are registered: the request register (_s1), then the decode and
//    state update that writes the result register.
//  - Throughput is one item per cycle while the receiver takes results; the
//    decoder state is read and written combinationally between the two
//    registers, so dependent items follow each other without bubbles.
//  - A stalled receiver holds the result register; the request register
//    still takes one more item, after which req_ready drops.
//  - Reset (arst_n low) empties both registers and returns the decoder to
//    waiting for the signature with zero frame size and no run pending.
// ---------------------------------------------------------------------------
module run_length_image_chunk_decoder
	import rlicd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,

	input  logic req_valid,
	output logic req_ready,
	input  req_t req,

	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	// request stage
	logic v_s1;
	req_t item_s1;

	// result register
	logic res_valid_q;
	res_t res_q;

	// decoder state
	phase_t      phase_q, phase_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [31:0] col_q, col_d;
	logic [31:0] row_q, row_d;
	logic [15:0] run_left_q, run_left_d;
	logic [31:0] run_color_q, run_color_d;

	logic adv;
	res_t res_d;

	// stage 1 moves into the result register when that is free or drained
	assign adv       = v_s1 && (!res_valid_q || res_ready);
	assign req_ready = !v_s1 || adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// chunk classification
	logic        all_zero, sig_match, close_mark, run_pending, pix_go, col_wrap;
	logic [31:0] be32, col_inc;

	assign all_zero = ({item_s1.byte0, item_s1.byte1, item_s1.byte2,
			item_s1.byte3, item_s1.byte4, item_s1.byte5} == 48'd0);
	assign sig_match = item_s1.byte0 == SIG_B0 && item_s1.byte1 == SIG_B1 &&
			item_s1.byte2 == SIG_B2 && item_s1.byte3 == SIG_B3 &&
			item_s1.byte4 == SIG_B4 && item_s1.byte5 == SIG_B5;
	assign close_mark = item_s1.byte0 == 8'd0 && item_s1.byte1 == 8'd0 &&
			item_s1.byte2 == END_MARK && item_s1.byte3 == END_MARK &&
			item_s1.byte4 == END_MARK && item_s1.byte5 == END_MARK;
	assign be32 = {item_s1.byte1, item_s1.byte2, item_s1.byte3, item_s1.byte4};
	assign run_pending = run_left_q != 16'd0;
	assign pix_go = item_s1.mode == MODE_PIXEL && phase_q == PH_PIXEL && run_pending;
	assign col_inc  = col_q + 32'd1;
	assign col_wrap = col_inc >= width_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (item_s1.mode == MODE_CHUNK) begin
			unique case (phase_q)
				PH_SIG: begin
					phase_d = sig_match ? PH_PARAM : PH_ERROR;
				end
				PH_PARAM: begin
					if (close_mark) begin
						phase_d = (width_q == 32'd0 || height_q == 32'd0) ?
								PH_ERROR : PH_PIXEL;
					end
				end
				PH_PIXEL: begin
					if (!run_pending && all_zero) begin
						phase_d = PH_ENDED;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result and datapath state
	always_comb begin
		res_d       = '0;
		width_d     = width_q;
		height_d    = height_q;
		col_d       = col_q;
		row_d       = row_q;
		run_left_d  = run_left_q;
		run_color_d = run_color_q;
		res_d.status = ST_OK;
		if (item_s1.mode == MODE_CHUNK) begin
			unique case (phase_q)
				PH_SIG: begin
					res_d.status = sig_match ? ST_OK : ST_BAD_MAGIC;
				end
				PH_PARAM: begin
					if (close_mark) begin
						if (width_q == 32'd0 || height_q == 32'd0) begin
							res_d.status = ST_ZERO_DIM;
						end else begin
							col_d      = '0;
							row_d      = '0;
							run_left_d = '0;
						end
					end else if (item_s1.byte0 == TAG_WIDTH) begin
						width_d = be32;
					end else if (item_s1.byte0 == TAG_HEIGHT) begin
						height_d = be32;
					end
				end
				PH_PIXEL: begin
					if (run_pending) begin
						res_d.status = ST_PENDING;
					end else if (all_zero) begin
						res_d.status = ST_ENDED;
					end else begin
						run_left_d  = {item_s1.byte0, item_s1.byte1};
						run_color_d = {item_s1.byte2, item_s1.byte3,
								item_s1.byte4, item_s1.byte5};
					end
				end
				default: begin
					res_d.status = ST_IGNORED;
				end
			endcase
		end else if (phase_q == PH_ENDED || phase_q == PH_ERROR) begin
			res_d.status = ST_IGNORED;
		end else if (pix_go) begin
			res_d.pixel_valid  = 1'b1;
			res_d.pix_x        = col_q;
			res_d.pix_y        = row_q;
			res_d.red          = run_color_q[31:24];
			res_d.green        = run_color_q[23:16];
			res_d.blue         = run_color_q[15:8];
			res_d.alpha        = run_color_q[7:0];
			res_d.run_last     = run_left_q == 16'd1;
			res_d.out_of_frame = row_q >= height_q;
			run_left_d = run_left_q - 16'd1;
			if (col_wrap) begin
				col_d = '0;
				row_d = row_q + 32'd1;
			end else begin
				col_d = col_inc;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q     <= PH_SIG;
			width_q     <= '0;
			height_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			run_left_q  <= '0;
			run_color_q <= '0;
		end else begin
			if (req_ready) begin
				v_s1 <= req_valid;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv) begin
				phase_q     <= phase_d;
				width_q     <= width_d;
				height_q    <= height_d;
				col_q       <= col_d;
				row_q       <= row_d;
				run_left_q  <= run_left_d;
				run_color_q <= run_color_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	// a run is only ever pending in the pixel phase
	a_run_in_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		run_left_q != 16'd0 |-> phase_q == PH_PIXEL)
		else $error("run pending outside pixel phase");

	// ended and error phases are terminal
	a_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ENDED || phase_q == PH_ERROR) |=> $stable(phase_q))
		else $error("left a terminal phase");

	// a pixel item always reports ok
	a_pix_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.pixel_valid |-> res.status == ST_OK)
		else $error("pixel with non-ok status");

	// items without a pixel carry zero pixel fields
	a_nopix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.pixel_valid |-> res.pix_x == 32'd0 &&
			res.pix_y == 32'd0 && !res.run_last && !res.out_of_frame)
		else $error("stale pixel fields");

	// each pixel step decrements the run count by exactly one
	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pix_go |=> run_left_q == $past(run_left_q) - 16'd1)
		else $error("run count did not step");

endmodule
